@@ rtl/button_click_hold_detector_macros.svh @@
// ----------------------------------------------------------------------------
// button click/hold detector assertion macros
// shared property wrappers, sampled on the rising edge and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_HOLD_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_MACROS_SVH

// same-cycle implication
`define BCHD_ASSERT_IMPL(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("bchd assertion failed");

// next-cycle implication
`define BCHD_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("bchd assertion failed");

`endif

@@ rtl/bchd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchd_pkg
// types and constants of the button click/hold detector
// ----------------------------------------------------------------------------
package bchd_pkg;

  localparam int CFG_BITS   = 16;
  localparam int CIDX_BITS  = 2;
  localparam int NOW_BITS   = 32;
  localparam int KIND_BITS  = 2;
  localparam int CCNT_BITS  = 8;
  localparam int DUR_BITS   = 32;

  typedef enum logic [CIDX_BITS-1:0] {
    REG_DEBOUNCE      = 2'd0,
    REG_CLICK_RELEASE = 2'd1,
    REG_HOLD_RELEASE  = 2'd2,
    REG_HOLD_MIN      = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_PIN_CHANGE = 1'b0,
    OP_POLL       = 1'b1
  } op_t;

  typedef enum logic [KIND_BITS-1:0] {
    EV_NONE       = 2'd0,
    EV_CLICKS_END = 2'd1,
    EV_HOLD_END   = 2'd2,
    EV_HOLD_ON    = 2'd3
  } event_kind_t;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RST      = 16'd50;
  localparam logic [CFG_BITS-1:0] CLICK_RELEASE_RST = 16'd300;
  localparam logic [CFG_BITS-1:0] HOLD_RELEASE_RST  = 16'd400;
  localparam logic [CFG_BITS-1:0] HOLD_MIN_RST      = 16'd600;

  typedef struct packed {
    event_kind_t          kind;
    logic [CCNT_BITS-1:0] count;
    logic [DUR_BITS-1:0]  dur;
    logic                 new_press;
  } result_t;

endpackage

@@ rtl/button_click_hold_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_hold_detector
// classifies button pin changes and service polls into clicks and holds
// ----------------------------------------------------------------------------
// usage:
//   input channel  in_valid/in_stall with in_op, in_button_level, in_now_ms;
//     op 0 is a pin change, op 1 a periodic service poll
//   output channel out_valid/out_stall, one result per input transfer
//   config port    cfg_we/cfg_index/cfg_wdata, written while idle
// timing:
//   the state update and the result are computed in the cycle of the input
//   transfer and the result is registered; one item is taken every cycle
//   while in_stall is low; the loop through the state registers is a few
//   subtractions and compares
// stall:
//   a skid register behind the output register takes one more item while the
//   output is stalled; in_stall rises only when the skid register is full
// reset:
//   rst_n clears all state, empties both result registers and loads the
//   default timing registers (50, 300, 400, 600 ms)
// ----------------------------------------------------------------------------
module button_click_hold_detector
  import bchd_pkg::*;
#(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic                 in_button_level,
  input  logic [NOW_BITS-1:0]  in_now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KIND_BITS-1:0] out_event_kind,
  output logic [CCNT_BITS-1:0] out_click_count,
  output logic [DUR_BITS-1:0]  out_press_duration,
  output logic                 out_new_press,
  input  logic                 cfg_we,
  input  logic [CIDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_wdata
);

  // configuration
  logic [CFG_BITS-1:0] debounce_r, click_rel_r, hold_rel_r, hold_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RST;
      click_rel_r <= CLICK_RELEASE_RST;
      hold_rel_r  <= HOLD_RELEASE_RST;
      hold_min_r  <= HOLD_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE:      debounce_r  <= cfg_wdata;
        REG_CLICK_RELEASE: click_rel_r <= cfg_wdata;
        REG_HOLD_RELEASE:  hold_rel_r  <= cfg_wdata;
        REG_HOLD_MIN:      hold_min_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // detector state
  logic [TIME_BITS-1:0]  last_press_r, last_press_nxt;
  logic [TIME_BITS-1:0]  first_hold_r, first_hold_nxt;
  logic [COUNT_BITS-1:0] clicks_r, clicks_nxt;
  logic                  pressed_r, pressed_nxt;
  logic                  long_r, long_nxt;
  logic                  trig_r, trig_nxt;
  logic                  seen_r, seen_nxt;

  logic                  in_xfer;
  logic [TIME_BITS-1:0]  now_w, since_w, dur_w;
  logic [TIME_BITS-1:0]  debounce_w, click_rel_w, hold_rel_w, hold_min_w;
  logic                  long_now, seq_end;
  result_t               res;

  assign in_xfer     = in_valid && !in_stall;
  assign now_w       = TIME_BITS'(in_now_ms);
  assign since_w     = now_w - last_press_r;
  assign dur_w       = now_w - first_hold_r;
  assign debounce_w  = TIME_BITS'(debounce_r);
  assign click_rel_w = TIME_BITS'(click_rel_r);
  assign hold_rel_w  = TIME_BITS'(hold_rel_r);
  assign hold_min_w  = TIME_BITS'(hold_min_r);

  assign long_now = pressed_r && (dur_w > hold_min_w);
  assign seq_end  = trig_r && ((!long_now && (since_w > click_rel_w)) ||
                               (long_now && (since_w > hold_rel_w)));

  always_comb begin
    last_press_nxt = last_press_r;
    first_hold_nxt = first_hold_r;
    clicks_nxt     = clicks_r;
    pressed_nxt    = pressed_r;
    long_nxt       = long_r;
    trig_nxt       = trig_r;
    seen_nxt       = seen_r;
    res.kind       = EV_NONE;
    res.count      = '0;
    res.dur        = '0;
    res.new_press  = 1'b0;

    case (op_t'(in_op))
      OP_PIN_CHANGE: begin
        if (in_button_level) begin
          if (!long_r && (since_w > debounce_w)) begin
            if (!(&clicks_r)) begin
              clicks_nxt = clicks_r + 1'b1;
            end
            first_hold_nxt = now_w;
            res.new_press  = 1'b1;
          end
          last_press_nxt = now_w;
          trig_nxt       = 1'b1;
          pressed_nxt    = 1'b1;
        end
        seen_nxt  = in_button_level;
        res.count = CCNT_BITS'(clicks_nxt);
      end
      OP_POLL: begin
        long_nxt  = long_now;
        res.count = CCNT_BITS'(clicks_r);
        if (seq_end) begin
          res.kind       = long_now ? EV_HOLD_END : EV_CLICKS_END;
          res.dur        = long_now ? DUR_BITS'(dur_w) : '0;
          pressed_nxt    = 1'b0;
          long_nxt       = 1'b0;
          clicks_nxt     = '0;
          first_hold_nxt = now_w;
          trig_nxt       = 1'b0;
        end
        if (seen_r) begin
          last_press_nxt = now_w;
        end
        // hold still running: report it and keep the sequence armed
        if (long_now && !seq_end) begin
          trig_nxt  = 1'b1;
          res.kind  = EV_HOLD_ON;
          res.count = CCNT_BITS'(clicks_r);
          res.dur   = DUR_BITS'(dur_w);
        end
        // clear a press flag left over from a missed release
        if (seen_r && !in_button_level && (dur_w > debounce_w)) begin
          seen_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_press_r <= '0;
      first_hold_r <= '0;
      clicks_r     <= '0;
      pressed_r    <= 1'b0;
      long_r       <= 1'b0;
      trig_r       <= 1'b0;
      seen_r       <= 1'b0;
    end else if (in_xfer) begin
      last_press_r <= last_press_nxt;
      first_hold_r <= first_hold_nxt;
      clicks_r     <= clicks_nxt;
      pressed_r    <= pressed_nxt;
      long_r       <= long_nxt;
      trig_r       <= trig_nxt;
      seen_r       <= seen_nxt;
    end
  end

  // output register with skid stage
  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    out_free;

  assign out_free = !out_v_r || !out_stall;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (out_free) begin
      out_v_nxt  = skid_v_r || in_xfer;
      out_nxt    = skid_v_r ? skid_r : res;
      skid_v_nxt = 1'b0;
    end else if (in_xfer) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign in_stall           = skid_v_r;
  assign out_valid          = out_v_r;
  assign out_event_kind     = out_r.kind;
  assign out_click_count    = out_r.count;
  assign out_press_duration = out_r.dur;
  assign out_new_press      = out_r.new_press;

endmodule

@@ rtl/bchd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchd_checker
// port-level checks of the button click/hold detector
// ----------------------------------------------------------------------------
`include "button_click_hold_detector_macros.svh"

module bchd_checker
  import bchd_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [KIND_BITS-1:0] out_event_kind,
  input logic [DUR_BITS-1:0]  out_press_duration,
  input logic                 out_new_press
);

  // a stalled result stays on the port
  `BCHD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // input backpressure only while a result waits at the output
  `BCHD_ASSERT_IMPL(a_stall_needs_out, clk, rst_n, in_stall, out_valid)

  // no duration reported for quiet results or ended click sequences
  `BCHD_ASSERT_IMPL(a_dur_zero, clk, rst_n,
    out_valid && (out_event_kind == EV_NONE || out_event_kind == EV_CLICKS_END),
    out_press_duration == '0)

  // a new click only comes from a pin change, which never reports an event
  `BCHD_ASSERT_IMPL(a_press_no_event, clk, rst_n, out_valid && out_new_press,
    out_event_kind == EV_NONE)

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (.*);
